[rtl/chained_hash_table_engine_top_assert.svh]
// Assertion macros for the hash table engine top level.
`ifndef CHAINED_HASH_TABLE_ENGINE_TOP_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CHTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CHTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/chte_pkg.sv]
// Shared widths and codes for the chained hash table engine.
`timescale 1ns / 1ps
package chte_pkg;

  localparam int KEY_W    = 31;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;
  localparam int ECOUNT_W = 11;
  localparam int CCOUNT_W = 32;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

endpackage

[rtl/chained_hash_table_engine_top.sv]
// Top level of the chained hash table engine: sequencer, bucket and pool memories.
`timescale 1ns / 1ps
// Chained hash table engine.
// Input channel: start with in_action, in_key, in_handle; a transfer happens at
//   a rising edge with start high and busy low. Action insert stores key/handle,
//   action lookup searches the key (in_handle ignored).
// Result channel: out_valid is high for exactly one cycle with out_status,
//   out_found_handle, out_element_count and out_collision_count. The receiver
//   cannot stall; each result is taken in the cycle it is shown.
// Steps: the key-modulo-BUCKETS unit registers the key, the quotient
//   (reciprocal multiply), the difference (back-multiply and subtract) and the
//   corrected remainder; then the bucket head memory is read, then the chain
//   entries, one pool read per cycle, and the result strobe is registered.
//   busy drops with the strobe, so a new item can be accepted at the edge
//   that ends the strobe cycle; no new item is taken before the last result.
// Reset: rst_n low (synchronous) empties the counters, then a clearing pass
//   writes every bucket head to empty, one per cycle, with busy high. The
//   entry pool is not cleared: entries are reached only once linked.
// Storage: one BUCKETS-deep head memory and one ENTRIES-deep pool memory, both
//   with registered reads. Items run one at a time, so a write never overlaps
//   a read of the same entry.
module chained_hash_table_engine_top import chte_pkg::*; #(
  parameter int BUCKETS = 1009,
  parameter int ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_action,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [HANDLE_W-1:0] in_handle,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [HANDLE_W-1:0] out_found_handle,
  output logic [ECOUNT_W-1:0] out_element_count,
  output logic [CCOUNT_W-1:0] out_collision_count
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int IW    = $clog2(ENTRIES);
  localparam int LW    = $clog2(ENTRIES + 1);   // link: 0 none, else index + 1
  localparam int ENT_W = KEY_W + HANDLE_W + LW;
  localparam logic [LW-1:0] ENT_L  = LW'(ENTRIES);
  localparam logic [BW-1:0] LAST_B = BW'(BUCKETS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_HREAD = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [BW-1:0]       clr_r, clr_nxt;
  logic                act_r;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [LW-1:0]       head_link_r;
  logic [LW-1:0]       steps_r, steps_nxt;
  logic [LW-1:0]       stored_r, stored_nxt;
  logic [CCOUNT_W-1:0] coll_r, coll_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, found_nxt;
  logic [ECOUNT_W-1:0] out_ecount_r;
  logic [CCOUNT_W-1:0] out_ccount_r;

  logic                accept;
  logic                hash_done;
  logic [BW-1:0]       hash_bucket;

  // memories
  logic [LW-1:0]    head_mem [BUCKETS];
  logic [ENT_W-1:0] ent_mem  [ENTRIES];
  logic [LW-1:0]    head_q;
  logic [ENT_W-1:0] ent_q;

  logic             head_rd_en, head_we;
  logic [BW-1:0]    head_waddr;
  logic [LW-1:0]    head_wdata;
  logic             ent_rd_en, ent_we;
  logic [LW-1:0]    link_sel, link_m1;
  logic [IW-1:0]    ent_raddr;
  logic [ENT_W-1:0] ent_wdata;

  logic                res_valid, res_hit;
  logic [KEY_W-1:0]    ent_key;
  logic [HANDLE_W-1:0] ent_handle;
  logic [LW-1:0]       ent_next;
  logic [LW-1:0]       new_next;
  logic [31:0]         stored_ext;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  chte_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .key    (in_key),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  assign ent_key    = ent_q[ENT_W-1 -: KEY_W];
  assign ent_handle = ent_q[LW +: HANDLE_W];
  assign ent_next   = ent_q[LW-1:0];

  assign link_m1   = link_sel - LW'(1);
  assign ent_raddr = link_m1[IW-1:0];

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    steps_nxt  = steps_r;
    stored_nxt = stored_r;
    coll_nxt   = coll_r;
    head_rd_en = 1'b0;
    head_we    = 1'b0;
    head_waddr = hash_bucket;
    head_wdata = '0;
    ent_rd_en  = 1'b0;
    ent_we     = 1'b0;
    link_sel   = head_q;
    res_valid  = 1'b0;
    res_hit    = 1'b0;
    status_nxt = ST_NOT_FOUND;
    found_nxt  = '0;
    new_next   = head_link_r;

    unique case (state_r)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        if (clr_r == LAST_B) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + BW'(1);
        end
      end
      S_IDLE: begin
        if (accept) state_nxt = S_HASH;
      end
      S_HASH: begin
        if (hash_done) begin
          head_rd_en = 1'b1;
          state_nxt  = S_HREAD;
        end
      end
      S_HREAD: begin
        new_next = head_q;
        // collision is counted before the walk, even if the insert is rejected
        if (act_r == ACT_INSERT && head_q != '0 && coll_r != '1) begin
          coll_nxt = coll_r + CCOUNT_W'(1);
        end
        if (head_q == '0 || head_q > ENT_L) begin
          res_valid = 1'b1;
        end else begin
          ent_rd_en = 1'b1;
          link_sel  = head_q;
          steps_nxt = LW'(1);
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        link_sel = ent_next;
        if (ent_key == key_r) begin
          res_valid = 1'b1;
          res_hit   = 1'b1;
        end else if (ent_next == '0 || ent_next > ENT_L || steps_r == ENT_L) begin
          res_valid = 1'b1;
        end else begin
          ent_rd_en = 1'b1;
          steps_nxt = steps_r + LW'(1);
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    if (res_valid) begin
      state_nxt = S_IDLE;
      if (act_r == ACT_INSERT) begin
        priority if (res_hit) begin
          status_nxt = ST_DUPLICATE;
        end else if (stored_r >= ENT_L) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          ent_we     = 1'b1;
          head_we    = 1'b1;
          head_waddr = hash_bucket;
          head_wdata = stored_r + LW'(1);
          stored_nxt = stored_r + LW'(1);
        end
      end else begin
        if (res_hit) begin
          status_nxt = ST_FOUND;
          found_nxt  = ent_handle;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
    end
  end

  assign ent_wdata  = {key_r, handle_r, new_next};
  assign stored_ext = 32'(stored_nxt);

  // bucket head memory
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (head_rd_en) head_q <= head_mem[hash_bucket];
  end

  // entry pool memory: {key, handle, next link}
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[stored_r[IW-1:0]] <= ent_wdata;
    if (ent_rd_en) ent_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      steps_r     <= '0;
      stored_r    <= '0;
      coll_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      steps_r     <= steps_nxt;
      stored_r    <= stored_nxt;
      coll_r      <= coll_nxt;
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_action;
      key_r    <= in_key;
      handle_r <= in_handle;
    end
    if (state_r == S_HREAD) head_link_r <= head_q;
    if (res_valid) begin
      out_status_r <= status_nxt;
      out_handle_r <= found_nxt;
      out_ecount_r <= stored_ext[ECOUNT_W-1:0];
      out_ccount_r <= coll_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_found_handle    = out_handle_r;
  assign out_element_count   = out_ecount_r;
  assign out_collision_count = out_ccount_r;

`include "chained_hash_table_engine_top_assert.svh"

  `CHTE_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == S_IDLE, "result strobe while busy")
  `CHTE_ASSERT_NEXT(a_accept_busy, accept, busy, "busy did not rise after a transfer")
  `CHTE_ASSERT_NOW(a_pool_bound, 1'b1, stored_r <= ENT_L, "stored count beyond pool size")
  `CHTE_ASSERT_NEXT(a_coll_mono, 1'b1, coll_r >= $past(coll_r), "collision count went down")
  `CHTE_ASSERT_NOW(a_hash_state, hash_done, state_r == S_HASH, "hash done outside hash wait")

endmodule

[rtl/chte_hash.sv]
// Key-modulo-bucket-count unit: reciprocal multiply, back-multiply, one correction.
`timescale 1ns / 1ps
module chte_hash import chte_pkg::*; #(
  parameter int BUCKETS = 1009,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [BW-1:0]    bucket
);

  // RECIP = floor(2^SHIFT / BUCKETS) < 2^(KEY_W+1). The quotient estimate
  // (key * RECIP) >> SHIFT is the true quotient or one below it, so the
  // remainder estimate is below 2 * BUCKETS and one subtract finishes it.
  localparam int SHIFT = KEY_W + BW;
  localparam int RW    = KEY_W + 1;
  localparam int PW    = KEY_W + RW;
  localparam int QW    = PW - SHIFT;
  localparam int DW    = BW + 1;
  localparam logic [RW-1:0]    RECIP = RW'((64'd1 << SHIFT) / BUCKETS);
  localparam logic [KEY_W-1:0] BK    = KEY_W'(BUCKETS);
  localparam logic [DW-1:0]    BK_D  = DW'(BUCKETS);

  logic [3:0]       stage_r;
  logic [KEY_W-1:0] key_r;
  logic [QW-1:0]    quot_r;
  logic [DW-1:0]    diff_r;
  logic [BW-1:0]    rem_r;
  logic [PW-1:0]    prod;
  logic [KEY_W-1:0] qb;
  logic [KEY_W-1:0] diff;
  logic [DW-1:0]    fix;

  assign prod = PW'(key_r) * PW'(RECIP);
  assign qb   = KEY_W'(quot_r) * BK;
  assign diff = key_r - qb;
  assign fix  = (diff_r >= BK_D) ? diff_r - BK_D : diff_r;

  // one stage bit per step: key load, quotient, difference, remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= {stage_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) key_r <= key;
    if (stage_r[0]) quot_r <= prod[PW-1:SHIFT];
    if (stage_r[1]) diff_r <= diff[DW-1:0];
    if (stage_r[2]) rem_r <= fix[BW-1:0];
  end

  assign done   = stage_r[3];
  assign bucket = rem_r;

endmodule

[tb/chained_hash_table_engine_top_test.sv]
// Self-checking testbench for the chained hash table engine top level.
`timescale 1ns / 1ps
module chained_hash_table_engine_top_test;
  import chte_pkg::*;

  // Table geometry: matches the defaults of the block.
  localparam int BUCKETS = 1009;
  localparam int ENTRIES = 1024;
  // A link is 0 for none, else entry index + 1, so it needs one bit over the index.
  localparam int LINK_W = 11;
  // Bound on the multiplier m so that bucket + m * BUCKETS still fits in 31 bits.
  localparam int unsigned MAX_STRIDE = 2128000;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // One result transfer, field by field.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] found_handle;
    logic [ECOUNT_W-1:0] element_count;
    logic [CCOUNT_W-1:0] collision_count;
  } table_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_action = ACT_INSERT;
  logic [KEY_W-1:0]    in_key = '0;
  logic [HANDLE_W-1:0] in_handle = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_found_handle;
  logic [ECOUNT_W-1:0] out_element_count;
  logic [CCOUNT_W-1:0] out_collision_count;

  // Shadow copy of the table: bucket heads, entry pool and counters.
  // All zero at time 0, which is the state right after reset.
  bit [LINK_W-1:0]   bucket_link [BUCKETS];
  bit [KEY_W-1:0]    pool_key    [ENTRIES];
  bit [HANDLE_W-1:0] pool_handle [ENTRIES];
  bit [LINK_W-1:0]   pool_next   [ENTRIES];
  int unsigned       entries_used = 0;
  bit [CCOUNT_W-1:0] collisions = '0;

  table_result_t pending_results[$];
  int unsigned   fail_count = 0;
  bit            sender_idles = 1'b1;

  chained_hash_table_engine_top #(
    .BUCKETS (BUCKETS),
    .ENTRIES (ENTRIES)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_key              (in_key),
    .in_handle           (in_handle),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_found_handle    (out_found_handle),
    .out_element_count   (out_element_count),
    .out_collision_count (out_collision_count)
  );

  always #1 clk = ~clk;

  // Walk one chain. Returns the entry index holding key, or -1.
  // A link past the pool ends the walk, and the walk is bounded by the pool size.
  function automatic int find_entry(bit [LINK_W-1:0] link, bit [KEY_W-1:0] key);
    int unsigned steps;
    int unsigned idx;
    steps = 0;
    while (link != 0 && steps < ENTRIES) begin
      idx = link - 1;
      if (idx >= ENTRIES) return -1;
      if (pool_key[idx] == key) return idx;
      link = pool_next[idx];
      steps++;
    end
    return -1;
  endfunction

  // Apply one item to the shadow table and return the result it should give.
  function automatic table_result_t apply_table_op(logic action, logic [KEY_W-1:0] key,
                                                   logic [HANDLE_W-1:0] handle);
    int unsigned   bucket;
    bit [LINK_W-1:0] head;
    int            hit;
    table_result_t r;
    bucket = key % BUCKETS;
    head   = bucket_link[bucket];
    hit    = find_entry(head, key);
    r      = '0;
    if (action == ACT_INSERT) begin
      // The collision is counted before the walk, so rejected inserts count too.
      if (head != 0 && collisions != '1) collisions++;
      if (hit >= 0) begin
        // Duplicate wins over pool full.
        r.status = ST_DUPLICATE;
      end else if (entries_used >= ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        pool_key[entries_used]    = key;
        pool_handle[entries_used] = handle;
        pool_next[entries_used]   = head;
        bucket_link[bucket]       = LINK_W'(entries_used + 1);
        entries_used++;
        r.status = ST_INSERTED;
      end
    end else if (hit >= 0) begin
      r.status       = ST_FOUND;
      r.found_handle = pool_handle[hit];
    end else begin
      r.status = ST_NOT_FOUND;
    end
    r.element_count   = ECOUNT_W'(entries_used);
    r.collision_count = collisions;
    return r;
  endfunction

  // A key in one of a few crowded buckets, including the first and last bucket.
  // These build long chains so that walks of many steps are exercised.
  function automatic logic [KEY_W-1:0] hot_bucket_key();
    int unsigned bucket;
    case ($urandom_range(0, 3))
      0:       bucket = 0;
      1:       bucket = 5;
      2:       bucket = 500;
      default: bucket = BUCKETS - 1;
    endcase
    return KEY_W'(bucket + BUCKETS * $urandom_range(0, MAX_STRIDE));
  endfunction

  // Mix of keys already stored, crowded-bucket keys and keys over the full range.
  function automatic logic [KEY_W-1:0] choose_key();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40 && entries_used != 0) return pool_key[$urandom_range(0, entries_used - 1)];
    if (pick < 60) return hot_bucket_key();
    return KEY_W'($urandom());
  endfunction

  // Drive one item and hold it until the block takes it. Called just after a
  // rising edge; returns in the step of the accepting edge, so a following
  // item keeps start high without a dip.
  task automatic send_item(logic action, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle);
    if (sender_idles && $urandom_range(0, 99) < 16) begin
      // Gaps of random length land on any phase of an item.
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    start     <= 1'b1;
    in_action <= action;
    in_key    <= key;
    in_handle <= handle;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(apply_table_op(action, key, handle));
  endtask

  // Hold the input off until every outstanding result has been checked.
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Empty table: lookups miss, first inserts see no collision, then a duplicate
  // into a non-empty bucket still counts one collision.
  task automatic test_empty_table();
    send_item(ACT_LOOKUP, '0, '1);            // handle is ignored on lookup
    send_item(ACT_LOOKUP, KEY_MAX, '0);
    send_item(ACT_INSERT, '0, '0);
    send_item(ACT_INSERT, KEY_MAX, '1);
    send_item(ACT_LOOKUP, '0, 16'h1234);
    send_item(ACT_LOOKUP, KEY_MAX, '0);
    send_item(ACT_INSERT, '0, 16'h1234);      // duplicate, bucket not empty
    send_item(ACT_LOOKUP, KEY_W'(BUCKETS), '0); // same bucket as key 0, absent
    send_item(ACT_LOOKUP, KEY_W'(1), '1);     // empty bucket
  endtask

  // Several keys in one bucket: hits at the head, in the middle and at the tail,
  // a miss that walks the whole chain, and a duplicate found at the tail.
  task automatic test_chain_collisions();
    logic [KEY_W-1:0] tail_key;
    logic [KEY_W-1:0] mid_key;
    logic [KEY_W-1:0] head_key;
    tail_key = KEY_MAX;
    mid_key  = KEY_MAX - KEY_W'(2 * BUCKETS);
    head_key = KEY_W'(KEY_MAX % BUCKETS);
    send_item(ACT_INSERT, KEY_MAX - KEY_W'(BUCKETS), 16'haaaa);
    send_item(ACT_INSERT, mid_key, 16'h5555);
    send_item(ACT_INSERT, head_key, 16'h0001);
    send_item(ACT_LOOKUP, tail_key, '0);
    send_item(ACT_LOOKUP, mid_key, '0);
    send_item(ACT_LOOKUP, head_key, '0);
    send_item(ACT_LOOKUP, head_key + KEY_W'(BUCKETS), '0);
    send_item(ACT_INSERT, tail_key, 16'hbeef);
  endtask

  // Random inserts and lookups; the middle third runs without input gaps.
  task automatic test_random_mix(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      sender_idles = (i < count / 3) || (i >= 2 * count / 3);
      send_item(logic'($urandom_range(0, 1)), choose_key(), HANDLE_W'($urandom()));
    end
    sender_idles = 1'b1;
  endtask

  // Fill the pool, then hit it with new keys (pool full, with and without a
  // collision), stored keys (duplicate over full) and lookups.
  task automatic test_pool_full();
    logic [KEY_W-1:0] key;
    while (entries_used < ENTRIES) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(ACT_LOOKUP, choose_key(), HANDLE_W'($urandom()));
      end else begin
        key = ($urandom_range(0, 3) == 0) ? hot_bucket_key() : KEY_W'($urandom());
        send_item(ACT_INSERT, key, HANDLE_W'($urandom()));
      end
    end
    send_item(ACT_INSERT, pool_key[0], '1);
    send_item(ACT_INSERT, hot_bucket_key(), '0);
    for (int i = 0; i < 80; i++) begin
      send_item(($urandom_range(0, 3) == 0) ? ACT_LOOKUP : ACT_INSERT, choose_key(),
                HANDLE_W'($urandom()));
    end
  endtask

  // Result checker: every strobe is matched to the oldest outstanding result.
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result transfer: status %0d handle %h count %0d collisions %0d",
                   out_status, out_found_handle, out_element_count, out_collision_count);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_found_handle !== want.found_handle ||
            out_element_count !== want.element_count ||
            out_collision_count !== want.collision_count) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected status %0d handle %h count %0d collisions %0d",
                     want.status, want.found_handle, want.element_count, want.collision_count);
            $display("          actual   status %0d handle %h count %0d collisions %0d",
                     out_status, out_found_handle, out_element_count, out_collision_count);
          end
        end
      end
    end
  end

  // Test sequence. Each phase drains before the next, so the sender also
  // pauses with nothing in flight; the clearing pass after reset is covered by
  // waiting on busy for the first transfer.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    wait_for_results();
    test_chain_collisions();
    wait_for_results();
    test_random_mix(1400);
    wait_for_results();
    test_pool_full();
    wait_for_results();
    // Items always give a result, so only a short tail for stray strobes.
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("chained_hash_table_engine_top test passed");
    end else begin
      $display("chained_hash_table_engine_top test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest run (long chains, gaps, clearing pass).
  initial begin
    #4000000;
    $display("chained_hash_table_engine_top test failed");
    $finish;
  end

endmodule
